// ----- design/ranging_timing_budget_calc_assert.svh -----
// Assertion macros for the ranging timing budget calculator.
// Used by the top level; expects signals clk and rst in scope.
`ifndef RANGING_TIMING_BUDGET_CALC_ASSERT_SVH
`define RANGING_TIMING_BUDGET_CALC_ASSERT_SVH

// Same-cycle implication.
`define RTBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rtbc_pkg.sv -----
// Package for the ranging timing budget calculator: constants, item structs
// and small arithmetic helpers. No dependencies.
`default_nettype none
package rtbc_pkg;

  localparam int unsigned OVH_START = 1910;
  localparam int unsigned OVH_END   = 960;
  localparam int unsigned OVH_MSRC  = 660;
  localparam int unsigned OVH_TCC   = 590;
  localparam int unsigned OVH_DSS   = 690;
  localparam int unsigned OVH_PRE   = 660;
  localparam int unsigned OVH_FINAL = 550;
  localparam int unsigned MACRO_VCLKS = 2304;
  localparam int unsigned PLL_TICK_PS = 1655;

  localparam int MP_W   = 20;  // macro period in ns, max 976159
  localparam int MCLK_W = 16;
  localparam int US_W   = 23;  // any 32-bit value over 1000
  localparam int DIV_W  = 32;
  localparam int DIV_BITS_PER_STAGE = 4;

  // (MACRO_VCLKS * PLL_TICK_PS) / 1000 integer part, and the rounding
  // term reciprocal for /50 on values below 1600.
  localparam int unsigned MP_INT  = (MACRO_VCLKS * PLL_TICK_PS) / 1000;
  localparam int unsigned RCP_50  = 1311;
  // ceil(2^36 / 125): exact x/125 for x < 2^29
  localparam logic [29:0] RCP_125 = 30'd549755814;
  localparam logic [31:0] MASK_HI = 32'hFFFFFF00;

  typedef struct packed {
    logic [7:0]  step_cfg;
    logic [7:0]  msrc_timeout_code;
    logic [15:0] pre_timeout_word;
    logic [15:0] final_timeout_word;
    logic [6:0]  pre_period_code;
    logic [6:0]  final_period_code;
    logic [31:0] requested_budget_us;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       current;
    logic [31:0]       used;
    logic              fits;
    logic              fin;
    logic              pre;
    logic [MCLK_W-1:0] pre_mclks;
  } carry_t;

  typedef struct packed {
    carry_t          c;
    logic [MP_W-1:0] divisor;
    logic [DIV_W-1:0] dividend;
  } front_out_t;

  // Macro period in ns, rounded: (2304*pclks*1655 + 500) / 1000.
  function automatic logic [MP_W-1:0] macro_ns(input logic [6:0] code);
    logic [7:0]  k;
    logic [10:0] x;
    logic [21:0] rnd;
    logic [MP_W-1:0] base;
    k    = {1'b0, code} + 8'd1;
    x    = 11'(12 * k) + 11'd25;
    rnd  = 22'(x * RCP_50) >> 16;
    base = MP_W'(MP_INT * 2 * k);
    return base + MP_W'(rnd);
  endfunction

  function automatic logic [MCLK_W-1:0] word_to_mclks(input logic [15:0] w);
    logic [15:0] v;
    v = (w[15:8] < 8'd16) ? (16'(w[7:0]) << w[11:8]) : 16'd0;
    return v + 16'd1;
  endfunction

  // floor(x/1000) as ((x>>3) * ceil(2^36/125)) >> 36
  function automatic logic [US_W-1:0] div1000(input logic [31:0] x);
    logic [58:0] p;
    p = 59'(x[31:3]) * 59'(RCP_125);
    return p[58:36];
  endfunction

endpackage
`default_nettype wire

// ----- design/rtbc_in_if.sv -----
// Input channel of the budget calculator: valid, ready and one item.
// No dependencies.
`default_nettype none
interface rtbc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  step_cfg;
  logic [7:0]  msrc_timeout_code;
  logic [15:0] pre_timeout_word;
  logic [15:0] final_timeout_word;
  logic [6:0]  pre_period_code;
  logic [6:0]  final_period_code;
  logic [31:0] requested_budget_us;

  modport source (output valid, step_cfg, msrc_timeout_code, pre_timeout_word,
                  final_timeout_word, pre_period_code, final_period_code,
                  requested_budget_us, input ready);
  modport sink   (input valid, step_cfg, msrc_timeout_code, pre_timeout_word,
                  final_timeout_word, pre_period_code, final_period_code,
                  requested_budget_us, output ready);
endinterface
`default_nettype wire

// ----- design/rtbc_out_if.sv -----
// Output channel of the budget calculator: valid, ready and one result item.
// No dependencies.
`default_nettype none
interface rtbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] current_budget_us;
  logic [31:0] spent_budget_us;
  logic        budget_fits;
  logic [15:0] new_final_word;
  logic        new_final_valid;

  modport source (output valid, current_budget_us, spent_budget_us, budget_fits,
                  new_final_word, new_final_valid, input ready);
  modport sink   (input valid, current_budget_us, spent_budget_us, budget_fits,
                  new_final_word, new_final_valid, output ready);
endinterface
`default_nettype wire

// ----- design/rtbc_front.sv -----
// Front end: decode, conversion products, divide by 1000, sums, fit check.
// Five register stages, all advancing on adv. Depends on rtbc_pkg.
`default_nettype none
module rtbc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire rtbc_pkg::in_item_t in_item,
  output logic                   out_valid,
  output rtbc_pkg::front_out_t   out_item
);

  localparam int MP_W   = rtbc_pkg::MP_W;
  localparam int MCLK_W = rtbc_pkg::MCLK_W;
  localparam int US_W   = rtbc_pkg::US_W;

  // stage 1: decode
  logic              s1_v, s1_fin, s1_pre, s1_tcc, s1_dss, s1_msrc;
  logic [8:0]        s1_msrc_n;
  logic [MCLK_W-1:0] s1_pre_mclks, s1_fin_mclks;
  logic [MP_W-1:0]   s1_pre_mp, s1_fin_mp;
  logic [31:0]       s1_req;
  logic [MCLK_W-1:0] pre_m, fin_m;

  assign pre_m = rtbc_pkg::word_to_mclks(in_item.pre_timeout_word);
  assign fin_m = rtbc_pkg::word_to_mclks(in_item.final_timeout_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= in_valid;
    end
    if (adv) begin
      s1_tcc       <= in_item.step_cfg[4];
      s1_dss       <= in_item.step_cfg[3];
      s1_msrc      <= in_item.step_cfg[2];
      s1_pre       <= in_item.step_cfg[6];
      s1_fin       <= in_item.step_cfg[7];
      s1_msrc_n    <= {1'b0, in_item.msrc_timeout_code} + 9'd1;
      s1_pre_mclks <= pre_m;
      s1_fin_mclks <= in_item.step_cfg[6] ? (fin_m - pre_m) : fin_m;
      s1_pre_mp    <= rtbc_pkg::macro_ns(in_item.pre_period_code);
      s1_fin_mp    <= rtbc_pkg::macro_ns(in_item.final_period_code);
      s1_req       <= in_item.requested_budget_us;
    end
  end

  // stage 2: mclks * period + 500, wrapping at 32 bits
  logic              s2_v, s2_fin, s2_pre, s2_tcc, s2_dss, s2_msrc;
  logic [31:0]       s2_msrc_p, s2_pre_p, s2_fin_p, s2_req;
  logic [MCLK_W-1:0] s2_pre_mclks;
  logic [MP_W-1:0]   s2_fin_mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
    if (adv) begin
      {s2_fin, s2_pre, s2_tcc, s2_dss, s2_msrc} <=
        {s1_fin, s1_pre, s1_tcc, s1_dss, s1_msrc};
      s2_msrc_p    <= 32'(s1_msrc_n) * 32'(s1_pre_mp) + 32'd500;
      s2_pre_p     <= 32'(s1_pre_mclks) * 32'(s1_pre_mp) + 32'd500;
      s2_fin_p     <= 32'(s1_fin_mclks) * 32'(s1_fin_mp) + 32'd500;
      s2_req       <= s1_req;
      s2_pre_mclks <= s1_pre_mclks;
      s2_fin_mp    <= s1_fin_mp;
    end
  end

  // stage 3: divide by 1000
  logic              s3_v, s3_fin, s3_pre, s3_tcc, s3_dss, s3_msrc;
  logic [US_W-1:0]   s3_msrc_us, s3_pre_us, s3_fin_us;
  logic [31:0]       s3_req;
  logic [MCLK_W-1:0] s3_pre_mclks;
  logic [MP_W-1:0]   s3_fin_mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
    if (adv) begin
      {s3_fin, s3_pre, s3_tcc, s3_dss, s3_msrc} <=
        {s2_fin, s2_pre, s2_tcc, s2_dss, s2_msrc};
      s3_msrc_us   <= rtbc_pkg::div1000(s2_msrc_p);
      s3_pre_us    <= rtbc_pkg::div1000(s2_pre_p);
      s3_fin_us    <= rtbc_pkg::div1000(s2_fin_p);
      s3_req       <= s2_req;
      s3_pre_mclks <= s2_pre_mclks;
      s3_fin_mp    <= s2_fin_mp;
    end
  end

  // stage 4: overhead sums
  logic              s4_v, s4_fin, s4_pre;
  logic [31:0]       s4_cur, s4_used, s4_req;
  logic [MCLK_W-1:0] s4_pre_mclks;
  logic [MP_W-1:0]   s4_fin_mp;
  logic [31:0]       base, t_tcc, t_dss, t_pre, t_fin;

  always_comb begin
    t_tcc = s3_tcc ? (32'(s3_msrc_us) + 32'(rtbc_pkg::OVH_TCC)) : 32'd0;
    if (s3_dss) begin
      t_dss = (32'(s3_msrc_us) + 32'(rtbc_pkg::OVH_DSS)) << 1;
    end else if (s3_msrc) begin
      t_dss = 32'(s3_msrc_us) + 32'(rtbc_pkg::OVH_MSRC);
    end else begin
      t_dss = 32'd0;
    end
    t_pre = s3_pre ? (32'(s3_pre_us) + 32'(rtbc_pkg::OVH_PRE)) : 32'd0;
    t_fin = s3_fin ? (32'(s3_fin_us) + 32'(rtbc_pkg::OVH_FINAL)) : 32'd0;
    base  = 32'(rtbc_pkg::OVH_START + rtbc_pkg::OVH_END) + t_tcc + t_dss + t_pre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
    if (adv) begin
      s4_fin       <= s3_fin;
      s4_pre       <= s3_pre;
      s4_cur       <= base + t_fin;
      s4_used      <= base + (s3_fin ? 32'(rtbc_pkg::OVH_FINAL) : 32'd0);
      s4_req       <= s3_req;
      s4_pre_mclks <= s3_pre_mclks;
      s4_fin_mp    <= s3_fin_mp;
    end
  end

  // stage 5: fit check and dividend for the rounded divide
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_v;
    end
    if (adv) begin
      out_item.c.current   <= s4_cur;
      out_item.c.used      <= s4_used;
      out_item.c.fits      <= !(s4_fin && (s4_used > s4_req));
      out_item.c.fin       <= s4_fin;
      out_item.c.pre       <= s4_pre;
      out_item.c.pre_mclks <= s4_pre_mclks;
      out_item.divisor     <= s4_fin_mp;
      out_item.dividend    <= (s4_req - s4_used) * 32'd1000 + 32'(s4_fin_mp >> 1);
    end
  end

endmodule
`default_nettype wire

// ----- design/rtbc_div.sv -----
// Pipelined restoring divider, STEPS quotient bits per stage.
// Carries the front-end item alongside. Depends on rtbc_pkg.
`default_nettype none
module rtbc_div #(
  parameter int STEPS = rtbc_pkg::DIV_BITS_PER_STAGE
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire rtbc_pkg::front_out_t in_item,
  output logic                      out_valid,
  output logic [rtbc_pkg::DIV_W-1:0] quotient,
  output rtbc_pkg::carry_t          out_carry
);

  localparam int DW = rtbc_pkg::DIV_W;
  localparam int MW = rtbc_pkg::MP_W;
  localparam int NS = DW / STEPS;

  logic                 v   [NS+1];
  logic [MW:0]          rem [NS+1];
  logic [DW-1:0]        dq  [NS+1];
  logic [MW-1:0]        dvs [NS+1];
  rtbc_pkg::carry_t     cr  [NS+1];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign dq[0]  = in_item.dividend;
  assign dvs[0] = in_item.divisor;
  assign cr[0]  = in_item.c;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [MW:0]   r;
    logic [DW-1:0] d;

    always_comb begin
      r = rem[s];
      d = dq[s];
      for (int j = 0; j < STEPS; j++) begin
        r = {r[MW-1:0], d[DW-1]};
        d = d << 1;
        if (r >= {1'b0, dvs[s]}) begin
          r    = r - {1'b0, dvs[s]};
          d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
      if (adv) begin
        rem[s+1] <= r;
        dq[s+1]  <= d;
        dvs[s+1] <= dvs[s];
        cr[s+1]  <= cr[s];
      end
    end
  end

  assign out_valid = v[NS];
  assign quotient  = dq[NS];
  assign out_carry = cr[NS];

endmodule
`default_nettype wire

// ----- design/rtbc_enc.sv -----
// Timeout encoder: adds pre-range mclks, finds the shift, forms the word.
// Two stages; the second is the output register. Depends on rtbc_pkg.
`default_nettype none
module rtbc_enc (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire logic [rtbc_pkg::DIV_W-1:0] quotient,
  input  wire rtbc_pkg::carry_t      in_carry,
  output logic                       out_valid,
  output logic [31:0]                current,
  output logic [31:0]                used,
  output logic                       fits,
  output logic [15:0]                word,
  output logic                       word_valid
);

  logic [31:0]      m, lsb;
  logic [4:0]       sh;
  logic             e_v, e_zero, e_ok;
  logic [31:0]      e_lsb, e_cur, e_used;
  logic [4:0]       e_sh;
  logic             e_fits;
  logic [31:0]      shifted;

  always_comb begin
    m   = quotient + (in_carry.pre ? 32'(in_carry.pre_mclks) : 32'd0);
    lsb = m - 32'd1;
    sh  = 5'd0;
    for (int i = 8; i < 32; i++) begin
      if (lsb[i]) sh = 5'(i - 7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= in_valid;
    end
    if (adv) begin
      e_zero <= (m == 32'd0);
      e_ok   <= in_carry.fin && in_carry.fits;
      e_lsb  <= lsb;
      e_sh   <= sh;
      e_cur  <= in_carry.current;
      e_used <= in_carry.used;
      e_fits <= in_carry.fits;
    end
  end

  assign shifted = e_lsb >> e_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_v;
    end
    if (adv) begin
      current    <= e_cur;
      used       <= e_used;
      fits       <= e_fits;
      word_valid <= e_ok;
      word       <= (e_ok && !e_zero) ? {3'b000, e_sh, shifted[7:0]} : 16'd0;
    end
  end

endmodule
`default_nettype wire

// ----- design/ranging_timing_budget_calc.sv -----
// Ranging timing budget calculator, fully pipelined, no state between items.
// Throughput: one item per cycle while the output is not stalled; the restoring divider stages set the depth.
// A stalled output freezes every stage together, so nothing is lost.
// Reset (synchronous, rst high) clears all stage valid bits; data is not reset.
`default_nettype none
`include "ranging_timing_budget_calc_assert.svh"
module ranging_timing_budget_calc #(
  // quotient bits resolved per divider stage; must divide DIV_W
  parameter int DIV_STEPS = rtbc_pkg::DIV_BITS_PER_STAGE
) (
  input wire logic  clk,
  input wire logic  rst,
  rtbc_in_if.sink   inp,
  rtbc_out_if.source outp
);

  // One enable for the whole pipe: move whenever the output register is
  // empty or being drained this cycle.
  logic adv;
  assign adv      = !outp.valid || outp.ready;
  assign inp.ready = adv;

  rtbc_pkg::in_item_t   item;
  rtbc_pkg::front_out_t f_item;
  rtbc_pkg::carry_t     d_carry;
  logic                 f_valid, d_valid;
  logic [rtbc_pkg::DIV_W-1:0] d_quot;

  assign item = '{
    step_cfg:            inp.step_cfg,
    msrc_timeout_code:   inp.msrc_timeout_code,
    pre_timeout_word:    inp.pre_timeout_word,
    final_timeout_word:  inp.final_timeout_word,
    pre_period_code:     inp.pre_period_code,
    final_period_code:   inp.final_period_code,
    requested_budget_us: inp.requested_budget_us
  };

  // period decode, conversions to us, overhead sums, fit check
  rtbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (inp.valid && adv),
    .in_item   (item),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  // rounded us-to-mclks divide by the final-range macro period
  rtbc_div #(.STEPS(DIV_STEPS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .out_valid (d_valid),
    .quotient  (d_quot),
    .out_carry (d_carry)
  );

  // timeout encode and output register
  rtbc_enc u_enc (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (d_valid),
    .quotient   (d_quot),
    .in_carry   (d_carry),
    .out_valid  (outp.valid),
    .current    (outp.current_budget_us),
    .used       (outp.spent_budget_us),
    .fits       (outp.budget_fits),
    .word       (outp.new_final_word),
    .word_valid (outp.new_final_valid)
  );

  // a new timeout is only offered when the request fits
  `RTBC_ASSERT_NOW(a_valid_needs_fit, outp.valid && outp.new_final_valid, outp.budget_fits,
    "new final timeout offered without fit")
  // no word without a valid new timeout
  `RTBC_ASSERT_NOW(a_word_zero, outp.valid && !outp.new_final_valid,
    outp.new_final_word == 16'd0, "word not zero when not produced")
  // a waiting result is held
  `RTBC_ASSERT_NEXT(a_hold, outp.valid && !outp.ready,
    outp.valid && $stable(outp.current_budget_us) && $stable(outp.new_final_word),
    "stalled result changed")
  // input side is free whenever the output is drained
  `RTBC_ASSERT_NOW(a_ready, outp.ready || !outp.valid, inp.ready,
    "input stalled with output free")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for ranging_timing_budget_calc: directed table, then random items
// checked against an in-bench budget predictor. Depends on rtbc_pkg,
// rtbc_in_if and rtbc_out_if.
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [31:0] current_budget_us;
    logic [31:0] spent_budget_us;
    logic        budget_fits;
    logic [15:0] new_final_word;
    logic        new_final_valid;
  } budget_res_t;

  // One directed row: item, plus a typed-in result where it is obvious.
  typedef struct packed {
    rtbc_pkg::in_item_t item;
    logic               typed;
    budget_res_t        res;
  } stim_row_t;

  // Sequence config step enables
  localparam logic [7:0] SEQ_TCC   = 8'h10;
  localparam logic [7:0] SEQ_DSS   = 8'h08;
  localparam logic [7:0] SEQ_MSRC  = 8'h04;
  localparam logic [7:0] SEQ_PRE   = 8'h40;
  localparam logic [7:0] SEQ_FINAL = 8'h80;
  localparam logic [7:0] SEQ_ALL   = 8'hDC;

  localparam int N_RANDOM     = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LATENCY      = 15;
  localparam int LONG_HOLD    = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rtbc_in_if  inp ();
  rtbc_out_if outp ();

  ranging_timing_budget_calc i_dut (
    .clk  (clk),
    .rst  (rst),
    .inp  (inp.sink),
    .outp (outp.source)
  );

  budget_res_t budget_q[$];
  int unsigned n_errors   = 0;
  int unsigned n_results  = 0;
  int unsigned n_sent     = 0;
  int unsigned n_nofit    = 0;
  int unsigned n_newword  = 0;
  bit          calm       = 1'b0;  // no idling in the closing stretch
  bit          hold_req   = 1'b0;  // asks the receiver for one long hold-off
  int unsigned cycle_cnt  = 0;

  // ---------------------------------------------------------------------
  // Budget predictor, 32-bit wrapping arithmetic throughout
  // ---------------------------------------------------------------------
  function automatic logic [31:0] period_ns(input logic [6:0] code);
    logic [31:0] pclks;
    pclks = (32'(code) + 32'd1) * 32'd2;
    return (32'd2304 * pclks * 32'd1655 + 32'd500) / 32'd1000;
  endfunction

  function automatic logic [31:0] decode_timeout(input logic [15:0] w);
    logic [31:0] v;
    v = (w[15:8] < 8'd16) ? ((32'(w[7:0]) << w[15:8]) & 32'hFFFF) : 32'd0;
    return (v + 32'd1) & 32'hFFFF;
  endfunction

  function automatic logic [15:0] encode_timeout(input logic [31:0] mclks);
    logic [31:0] lsb;
    logic [31:0] msb;
    if (mclks == 32'd0) return 16'd0;
    lsb = mclks - 32'd1;
    msb = 32'd0;
    while ((lsb & 32'hFFFFFF00) != 32'd0) begin
      lsb = lsb >> 1;
      msb = msb + 32'd1;
    end
    return 16'((msb << 8) | (lsb & 32'hFF));
  endfunction

  function automatic logic [31:0] mclks_us(input logic [31:0] m, input logic [31:0] mp);
    return (m * mp + 32'd500) / 32'd1000;
  endfunction

  function automatic budget_res_t predict_budget(input rtbc_pkg::in_item_t it);
    logic [31:0] pre_mp, fin_mp, msrc_us, pre_m, pre_us, fin_m, fin_us, base, m;
    budget_res_t r;
    pre_mp  = period_ns(it.pre_period_code);
    fin_mp  = period_ns(it.final_period_code);
    msrc_us = mclks_us(32'(it.msrc_timeout_code) + 32'd1, pre_mp);
    pre_m   = decode_timeout(it.pre_timeout_word);
    pre_us  = mclks_us(pre_m, pre_mp);
    fin_m   = decode_timeout(it.final_timeout_word);
    if (it.step_cfg[6]) fin_m = (fin_m - pre_m) & 32'hFFFF;
    fin_us  = mclks_us(fin_m, fin_mp);
    base    = 32'd1910 + 32'd960;
    if (it.step_cfg[4]) base += msrc_us + 32'd590;
    if (it.step_cfg[3]) base += 32'd2 * (msrc_us + 32'd690);
    else if (it.step_cfg[2]) base += msrc_us + 32'd660;
    if (it.step_cfg[6]) base += pre_us + 32'd660;
    r = '0;
    r.current_budget_us = base;
    r.spent_budget_us   = base;
    r.budget_fits       = 1'b1;
    if (it.step_cfg[7]) begin
      r.current_budget_us = base + fin_us + 32'd550;
      r.spent_budget_us   = base + 32'd550;
      if (r.spent_budget_us > it.requested_budget_us) begin
        r.budget_fits = 1'b0;
      end else begin
        m = ((it.requested_budget_us - r.spent_budget_us) * 32'd1000 + fin_mp / 32'd2)
            / fin_mp;
        if (it.step_cfg[6]) m += pre_m;
        r.new_final_word  = encode_timeout(m);
        r.new_final_valid = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table. Typed rows: with all steps off the budget is just the
  // start and end overheads; final-only with an all-ones word decodes to one
  // macro period of 7626 ns, i.e. 8 us, and a zero request cannot fit.
  // ---------------------------------------------------------------------
  localparam budget_res_t RES_BARE  = '{32'd2870, 32'd2870, 1'b1, 16'd0, 1'b0};
  localparam budget_res_t RES_NOFIT = '{32'd3428, 32'd3420, 1'b0, 16'd0, 1'b0};

  stim_row_t directed[] = '{
    '{'{8'h00, 8'h00, 16'h0000, 16'h0000, 7'd0,   7'd0,   32'h0},          1'b1, RES_BARE},
    '{'{8'h23, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127, 32'hFFFFFFFF},   1'b1, RES_BARE},
    '{'{SEQ_FINAL, 8'h00, 16'h0000, 16'hFFFF, 7'd0, 7'd0, 32'h0},          1'b1, RES_NOFIT},
    '{'{SEQ_ALL, 8'hFF, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{SEQ_ALL, 8'h00, 16'h0000, 16'h0000, 7'd0, 7'd0, 32'h0},            1'b0, '0},
    '{'{SEQ_TCC, 8'h2A, 16'h0103, 16'h0000, 7'd7, 7'd0, 32'd0},            1'b0, '0},
    '{'{SEQ_DSS, 8'h2A, 16'h0000, 16'h0000, 7'd7, 7'd0, 32'd0},            1'b0, '0},
    '{'{SEQ_MSRC, 8'h80, 16'h0000, 16'h0000, 7'd13, 7'd0, 32'd0},          1'b0, '0},
    '{'{SEQ_DSS | SEQ_MSRC, 8'h10, 16'h0000, 16'h0000, 7'd9, 7'd0, 32'd0}, 1'b0, '0},
    '{'{SEQ_PRE, 8'h00, 16'h0F80, 16'h0000, 7'd7, 7'd5, 32'd0},            1'b0, '0},
    '{'{SEQ_PRE, 8'h00, 16'h10FF, 16'h0000, 7'd7, 7'd5, 32'd0},            1'b0, '0},
    '{'{SEQ_FINAL, 8'h00, 16'h0000, 16'h02A3, 7'd7, 7'd5, 32'd33000},      1'b0, '0},
    '{'{SEQ_FINAL | SEQ_PRE, 8'h00, 16'h0105, 16'h0001, 7'd7, 7'd5, 32'd33000}, 1'b0, '0},
    '{'{SEQ_ALL, 8'h1D, 16'h0104, 16'h01FE, 7'd13, 7'd9, 32'd20000},       1'b0, '0},
    '{'{SEQ_FINAL, 8'h00, 16'h0000, 16'h0000, 7'd0, 7'd0, 32'd3420},       1'b0, '0},
    '{'{SEQ_FINAL, 8'h00, 16'h0000, 16'h0000, 7'd0, 7'd0, 32'd3421},       1'b0, '0},
    '{'{SEQ_FINAL, 8'h00, 16'h0000, 16'h0000, 7'd0, 7'd0, 32'd3419},       1'b0, '0},
    '{'{SEQ_FINAL, 8'h00, 16'h0000, 16'h0000, 7'd127, 7'd127, 32'hFFFFFFFF}, 1'b0, '0},
    '{'{SEQ_FINAL | SEQ_PRE, 8'h00, 16'h0FFF, 16'h0000, 7'd0, 7'd127, 32'h80000000},
      1'b0, '0}
  };

  // ---------------------------------------------------------------------
  // Random item: mostly sane timeout words and requests near the used
  // budget, so both the fit and no-fit branches get plenty of traffic.
  // ---------------------------------------------------------------------
  function automatic rtbc_pkg::in_item_t random_item();
    rtbc_pkg::in_item_t it;
    budget_res_t        r;
    it.step_cfg          = 8'($urandom);
    if ($urandom_range(0, 3) != 0) it.step_cfg[7] = 1'b1;
    it.msrc_timeout_code = 8'($urandom);
    it.pre_timeout_word  = 16'($urandom);
    it.final_timeout_word = 16'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      it.pre_timeout_word[15:8]   = 8'($urandom_range(0, 17));
      it.final_timeout_word[15:8] = 8'($urandom_range(0, 17));
    end
    if ($urandom_range(0, 3) == 0) begin
      it.pre_period_code   = 7'($urandom);
      it.final_period_code = 7'($urandom);
    end else begin
      it.pre_period_code   = 7'($urandom_range(5, 10));
      it.final_period_code = 7'($urandom_range(3, 8));
    end
    it.requested_budget_us = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      r = predict_budget(it);
      it.requested_budget_us = r.spent_budget_us + $urandom_range(0, 100000)
                               - $urandom_range(0, 3000);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  task automatic send_item(input rtbc_pkg::in_item_t it, input bit typed,
                           input budget_res_t res);
    inp.step_cfg            <= it.step_cfg;
    inp.msrc_timeout_code   <= it.msrc_timeout_code;
    inp.pre_timeout_word    <= it.pre_timeout_word;
    inp.final_timeout_word  <= it.final_timeout_word;
    inp.pre_period_code     <= it.pre_period_code;
    inp.final_period_code   <= it.final_period_code;
    inp.requested_budget_us <= it.requested_budget_us;
    inp.valid               <= 1'b1;
    @(posedge clk);
    while (!inp.ready) @(posedge clk);
    // accepted at this edge
    budget_q.push_back(typed ? res : predict_budget(it));
    n_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      inp.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  initial begin
    inp.valid               = 1'b0;
    inp.step_cfg            = '0;
    inp.msrc_timeout_code   = '0;
    inp.pre_timeout_word    = '0;
    inp.final_timeout_word  = '0;
    inp.pre_period_code     = '0;
    inp.final_period_code   = '0;
    inp.requested_budget_us = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].item, directed[i].typed, directed[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 400) hold_req <= 1'b1;      // receiver stalls, pipe backs up
      if (i == 900) begin
        // drain completely before going on
        inp.valid <= 1'b0;
        wait (budget_q.size() == 0);
        @(posedge clk);
      end
      if (i == N_RANDOM - 200) calm <= 1'b1;
      send_item(random_item(), 1'b0, '0);
    end
    inp.valid <= 1'b0;

    wait (budget_q.size() == 0);
    repeat (LATENCY * 2) @(posedge clk);
    $display("Sent %0d items, %0d results checked (%0d no-fit, %0d new final words).",
             n_sent, n_results, n_nofit, n_newword);
    $display("Covered all step enables, timeout shifts past 15, period codes 0..127.");
    if (n_errors == 0 && budget_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure bursts, one long hold-off on request
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit          hold_done  = 1'b0;
  budget_res_t exp_r;

  initial outp.ready = 1'b0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst) begin
      if (outp.valid && outp.ready) begin
        n_results++;
        if (budget_q.size() == 0) begin
          $error("result with no item outstanding");
          n_errors++;
        end else begin
          exp_r = budget_q.pop_front();
          if (!exp_r.budget_fits) n_nofit++;
          if (exp_r.new_final_valid) n_newword++;
          if (outp.current_budget_us !== exp_r.current_budget_us) begin
            $error("current_budget_us exp %0d got %0d", exp_r.current_budget_us,
                   outp.current_budget_us);
            n_errors++;
          end
          if (outp.spent_budget_us !== exp_r.spent_budget_us) begin
            $error("spent_budget_us exp %0d got %0d", exp_r.spent_budget_us,
                   outp.spent_budget_us);
            n_errors++;
          end
          if (outp.budget_fits !== exp_r.budget_fits) begin
            $error("budget_fits exp %0b got %0b", exp_r.budget_fits, outp.budget_fits);
            n_errors++;
          end
          if (outp.new_final_word !== exp_r.new_final_word) begin
            $error("new_final_word exp %h got %h", exp_r.new_final_word,
                   outp.new_final_word);
            n_errors++;
          end
          if (outp.new_final_valid !== exp_r.new_final_valid) begin
            $error("new_final_valid exp %0b got %0b", exp_r.new_final_valid,
                   outp.new_final_valid);
            n_errors++;
          end
        end
      end

      if (hold_req && !hold_done) begin
        hold_done  <= 1'b1;
        stall_left <= LONG_HOLD;
        outp.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        outp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left <= $urandom_range(0, 8);
        outp.ready <= 1'b0;
      end else begin
        outp.ready <= 1'b1;
      end
    end

    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_cnt, budget_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
`default_nettype wire
